/* rtl/bracketed_turtle_interpreter_defines.svh */
// ----------------------------------------------------------------------------
// bracketed turtle interpreter assertion macros
// shared property wrappers for the checker, clocked on clk
// ----------------------------------------------------------------------------
`ifndef BRACKETED_TURTLE_INTERPRETER_DEFINES_SVH
`define BRACKETED_TURTLE_INTERPRETER_DEFINES_SVH

// property checked only outside reset
`define BTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define BTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bti_pkg.sv */
// ----------------------------------------------------------------------------
// bti_pkg
// shared types and constants of the bracketed turtle interpreter
// ----------------------------------------------------------------------------
package bti_pkg;

  // turtle symbols
  localparam logic [7:0] SYM_DRAW   = 8'h46;  // F
  localparam logic [7:0] SYM_TURN_L = 8'h2B;  // +
  localparam logic [7:0] SYM_TURN_R = 8'h2D;  // -
  localparam logic [7:0] SYM_PUSH   = 8'h5B;  // [
  localparam logic [7:0] SYM_POP    = 8'h5D;  // ]

  typedef enum logic [1:0] {
    KIND_SEGMENT   = 2'd0,
    KIND_UNDERFLOW = 2'd1,
    KIND_OVERFLOW  = 2'd2
  } kind_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_DEC    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd5;

  // register reset values
  localparam logic [15:0]        RST_TURN_ANGLE    = 16'd4096;
  localparam logic [14:0]        RST_LENGTH_DEC    = 15'd26;
  localparam logic signed [15:0] RST_INITIAL_LEN   = 16'sd5120;
  localparam logic signed [23:0] RST_START_X       = 24'sd81920;
  localparam logic signed [23:0] RST_START_Y       = 24'sd0;
  localparam logic [15:0]        RST_START_HEADING = 16'd16384;

  localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] POS_MIN = 24'sh800000;
  localparam logic signed [15:0] LEN_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [15:0]        heading;
    logic signed [15:0] length;
  } turtle_state_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

endpackage

/* rtl/bracketed_turtle_interpreter.sv */
// ----------------------------------------------------------------------------
// bracketed_turtle_interpreter
// turtle graphics interpreter for bracketed l-system symbol streams
// ----------------------------------------------------------------------------
// One symbol word enters per clock while out_tready stays high; it is held in
// the input register, then its segment or error word is written into the
// output register and offered on out_tvalid, and a stall on out_tready keeps
// the symbol in the input register. The turtle state loop (position, heading,
// length) closes around a 16x16 multiply and a saturating 24-bit add; sine and
// cosine come from a registered quarter-wave table addressed from the next
// heading. The saved-state stack keeps its top entry in a register and
// STACK_DEPTH-1 entries in a memory whose next entry is always prefetched, so
// push and pop also run every cycle. After reset and each start_heading write,
// in_tready is low through the LOAD_START and LOAD_CUR states while the table
// is read for the start heading. Configuration is taken at any time; the turn
// angle and length decrement act on the next symbol, the rest at a restart.
// ----------------------------------------------------------------------------
module bracketed_turtle_interpreter
  import bti_pkg::*;
#(
  parameter int STACK_DEPTH     = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input symbols
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // symbol[7:0]
  input  logic [0:0]           in_tuser,   // restart[0]
  // results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [127:0]         out_tdata,  // seg_start_x[23:0], seg_start_y[47:24],
                                           // seg_end_x[71:48], seg_end_y[95:72],
                                           // seg_heading[111:96], seg_length[127:112]
  output logic [1:0]           out_tuser,  // result_kind[1:0]
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_data
);

  // table load sequence, then normal running
  typedef enum logic [2:0] {
    MODE_LOAD_START = 3'b001,
    MODE_LOAD_CUR   = 3'b010,
    MODE_RUN        = 3'b100
  } mode_t;

  mode_t mode_r, mode_nxt;

  // configuration registers
  logic [15:0]        turn_angle_r;
  logic [14:0]        len_dec_r;
  logic signed [15:0] init_len_r;
  logic signed [23:0] start_x_r, start_y_r;
  logic [15:0]        start_heading_r;
  logic signed [15:0] start_sin_r, start_cos_r;

  // input register
  logic       in_v_r;
  logic [7:0] sym_r;
  logic       restart_r;

  // turtle state and its trig
  turtle_state_t      cur_r, cur_nxt, eff;
  logic signed [15:0] cur_sin, cur_cos, eff_sin, eff_cos;
  logic [15:0]        rom_angle;

  // stack
  stk_cmd_t      stk_cmd;
  stk_stat_t     stk_stat;
  turtle_state_t stk_tos;
  logic          empty_eff, full_eff;

  // datapath
  logic               run, adv, cfg_fire;
  logic signed [31:0] prod_x, prod_y;
  logic [31:0]        rnd_x, rnd_y;
  logic [16:0]        dx, dy;
  logic [24:0]        sum_x, sum_y;
  logic signed [23:0] end_x, end_y;
  logic [16:0]        push_len;
  logic signed [15:0] push_len_sat;

  // result
  logic   has_res;
  kind_t  res_kind;
  logic [127:0] res_data;
  logic   out_v_r;
  kind_t  out_kind_r;
  logic [127:0] out_data_r;

  // ---- handshakes ----
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign run       = (mode_r == MODE_RUN);
  // in run mode the held symbol moves on when the result slot is free or draining
  assign adv       = in_v_r && run && (!out_v_r || out_tready);
  assign in_tready = run && (!in_v_r || adv);

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_angle_r    <= RST_TURN_ANGLE;
      len_dec_r       <= RST_LENGTH_DEC;
      init_len_r      <= RST_INITIAL_LEN;
      start_x_r       <= RST_START_X;
      start_y_r       <= RST_START_Y;
      start_heading_r <= RST_START_HEADING;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_TURN_ANGLE:    turn_angle_r    <= cfg_data[15:0];
        CFG_LENGTH_DEC:    len_dec_r       <= cfg_data[14:0];
        CFG_INITIAL_LEN:   init_len_r      <= $signed(cfg_data[15:0]);
        CFG_START_X:       start_x_r       <= $signed(cfg_data);
        CFG_START_Y:       start_y_r       <= $signed(cfg_data);
        CFG_START_HEADING: start_heading_r <= cfg_data[15:0];
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // ---- table load sequencer ----
  // the start heading trig is read once and kept, so a restart can draw
  // in the same cycle; the current heading is then read back again
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      MODE_LOAD_START: mode_nxt = MODE_LOAD_CUR;
      MODE_LOAD_CUR:   mode_nxt = MODE_RUN;
      MODE_RUN:        mode_nxt = MODE_RUN;
      default:         mode_nxt = MODE_LOAD_START;
    endcase
    if (cfg_fire && (cfg_index == CFG_START_HEADING)) begin
      mode_nxt = MODE_LOAD_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LOAD_START;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mode_r == MODE_LOAD_CUR) begin
      start_sin_r <= cur_sin;
      start_cos_r <= cur_cos;
    end
  end

  // ---- sine table ----
  // addressed from the next heading so its output matches cur_r.heading
  assign rom_angle = (mode_r == MODE_LOAD_START) ? start_heading_r : cur_nxt.heading;

  bti_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk   (clk),
    .angle (rom_angle),
    .sin_q (cur_sin),
    .cos_q (cur_cos)
  );

  // ---- input register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sym_r     <= in_tdata;
      restart_r <= in_tuser[0];
    end
  end

  // ---- state seen by the symbol: restart loads the start state first ----
  always_comb begin
    if (restart_r) begin
      eff.x       = start_x_r;
      eff.y       = start_y_r;
      eff.heading = start_heading_r;
      eff.length  = init_len_r;
      eff_sin     = start_sin_r;
      eff_cos     = start_cos_r;
    end else begin
      eff     = cur_r;
      eff_sin = cur_sin;
      eff_cos = cur_cos;
    end
  end

  // restart empties the stack before the symbol acts
  assign empty_eff = restart_r || stk_stat.empty;
  assign full_eff  = !restart_r && stk_stat.full;

  // ---- move: round half up, then saturating add ----
  assign prod_x = $signed(eff.length) * $signed(eff_cos);
  assign prod_y = $signed(eff.length) * $signed(eff_sin);
  assign rnd_x  = prod_x + 32'sd8192;
  assign rnd_y  = prod_y + 32'sd8192;
  assign dx     = rnd_x[30:14];
  assign dy     = rnd_y[30:14];
  assign sum_x  = {eff.x[23], eff.x} + {{8{dx[16]}}, dx};
  assign sum_y  = {eff.y[23], eff.y} + {{8{dy[16]}}, dy};

  always_comb begin
    if (sum_x[24] != sum_x[23]) begin
      end_x = sum_x[24] ? POS_MIN : POS_MAX;
    end else begin
      end_x = sum_x[23:0];
    end
    if (sum_y[24] != sum_y[23]) begin
      end_y = sum_y[24] ? POS_MIN : POS_MAX;
    end else begin
      end_y = sum_y[23:0];
    end
  end

  // shortened length on push, floors at the most negative length
  assign push_len     = {eff.length[15], eff.length} - {2'b00, len_dec_r};
  assign push_len_sat = (push_len[16] != push_len[15]) ? LEN_MIN : push_len[15:0];

  // ---- symbol decode ----
  always_comb begin
    cur_nxt       = cur_r;
    stk_cmd.clear = adv && restart_r;
    stk_cmd.push  = 1'b0;
    stk_cmd.pop   = 1'b0;
    has_res       = 1'b0;
    res_kind      = KIND_SEGMENT;
    res_data      = '0;
    if (adv) begin
      cur_nxt = eff;
      case (sym_r)
        SYM_DRAW: begin
          cur_nxt.x = end_x;
          cur_nxt.y = end_y;
          has_res   = 1'b1;
          res_data  = {eff.length, eff.heading, end_y, end_x, eff.y, eff.x};
        end
        SYM_TURN_L: cur_nxt.heading = eff.heading + turn_angle_r;
        SYM_TURN_R: cur_nxt.heading = eff.heading - turn_angle_r;
        SYM_PUSH: begin
          if (full_eff) begin
            has_res  = 1'b1;
            res_kind = KIND_OVERFLOW;
          end else begin
            stk_cmd.push   = 1'b1;
            cur_nxt.length = push_len_sat;
          end
        end
        SYM_POP: begin
          if (empty_eff) begin
            has_res  = 1'b1;
            res_kind = KIND_UNDERFLOW;
          end else begin
            stk_cmd.pop = 1'b1;
            cur_nxt     = stk_tos;
          end
        end
        default: ;  // other symbols leave the turtle alone
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.x       <= RST_START_X;
      cur_r.y       <= RST_START_Y;
      cur_r.heading <= RST_START_HEADING;
      cur_r.length  <= RST_INITIAL_LEN;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  // ---- saved states ----
  bti_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .din   (eff),
    .tos   (stk_tos),
    .stat  (stk_stat)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && has_res) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

/* rtl/bti_sine_rom.sv */
// ----------------------------------------------------------------------------
// bti_sine_rom
// quarter-wave sine table, two registered reads giving sin and cos in q14
// ----------------------------------------------------------------------------
module bti_sine_rom
  import bti_pkg::*;
#(
  parameter int TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic [15:0]        angle,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q
);

  localparam int TAB_N = 1 << TABLE_BITS;
  localparam int IW = TABLE_BITS + 1;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  // (2n)(2n+1) for n = 1 .. 8
  localparam logic [63:0] HORNER_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210, 64'd272};

  // one table entry, evaluated at elaboration only
  function automatic logic [14:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(k) * HALF_PI_Q30) >> TABLE_BITS;
    x2 = (x * x) >> 30;
    s  = Q30_ONE;
    for (int n = 7; n >= 0; n--) begin
      s = Q30_ONE - ((x2 * s) >> 30) / HORNER_DIV[n];
    end
    v = (((x * s) >> 30) + 64'd32768) >> 16;
    return (v > 64'd16384) ? 15'd16384 : v[14:0];
  endfunction

  logic [14:0] rom [0:TAB_N];

  for (genvar k = 0; k <= TAB_N; k++) begin : g_rom
    assign rom[k] = sine_entry(k);
  end

  logic [15:0]           cos_angle;
  logic [1:0]            quad_s, quad_c;
  logic [TABLE_BITS-1:0] frac_s, frac_c;
  logic [IW-1:0]         idx_s, idx_c;
  logic [14:0]           mag_s_r, mag_c_r;
  logic                  neg_s_r, neg_c_r;

  assign cos_angle = angle + QUARTER_TURN;
  assign quad_s = angle[15:14];
  assign quad_c = cos_angle[15:14];
  assign frac_s = angle[13:14-TABLE_BITS];
  assign frac_c = cos_angle[13:14-TABLE_BITS];

  // odd quadrants run the table backwards
  assign idx_s = quad_s[0] ? (IW'(TAB_N) - IW'(frac_s)) : IW'(frac_s);
  assign idx_c = quad_c[0] ? (IW'(TAB_N) - IW'(frac_c)) : IW'(frac_c);

  always_ff @(posedge clk) begin
    mag_s_r <= rom[idx_s];
    mag_c_r <= rom[idx_c];
    neg_s_r <= quad_s[1];
    neg_c_r <= quad_c[1];
  end

  assign sin_q = neg_s_r ? -$signed({1'b0, mag_s_r}) : $signed({1'b0, mag_s_r});
  assign cos_q = neg_c_r ? -$signed({1'b0, mag_c_r}) : $signed({1'b0, mag_c_r});

endmodule

/* rtl/bti_stack.sv */
// ----------------------------------------------------------------------------
// bti_stack
// saved turtle states: top entry in a register, the rest in a memory,
// with the entry below the top prefetched into a register
// ----------------------------------------------------------------------------
module bti_stack
  import bti_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stk_cmd_t      cmd,
  input  turtle_state_t din,
  output turtle_state_t tos,
  output stk_stat_t     stat
);

  localparam int MEM_DEPTH = (DEPTH > 1) ? DEPTH - 1 : 1;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt, base;
  turtle_state_t tos_r, tos_nxt, nos_r;
  turtle_state_t mem [0:MEM_DEPTH-1];
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          bypass;

  always_comb begin
    base      = cmd.clear ? '0 : count_r;
    count_nxt = base;
    tos_nxt   = tos_r;
    wr_en     = 1'b0;
    if (cmd.push) begin
      // old top moves down into the memory
      wr_en     = (base != '0);
      count_nxt = base + CW'(1);
      tos_nxt   = din;
    end else if (cmd.pop) begin
      count_nxt = base - CW'(1);
      tos_nxt   = nos_r;
    end
  end

  assign wr_addr = AW'(base - CW'(1));
  // keep the entry just below the next top ready
  assign rd_addr = AW'(count_nxt - CW'(2));
  assign bypass  = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (wr_en) begin
      mem[wr_addr] <= tos_r;
    end
    nos_r <= bypass ? tos_r : mem[rd_addr];
  end

  assign tos        = tos_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));

endmodule

/* rtl/bti_checker.sv */
// ----------------------------------------------------------------------------
// bti_checker
// port-level checks for the bracketed turtle interpreter
// ----------------------------------------------------------------------------
`include "bracketed_turtle_interpreter_defines.svh"

module bti_checker
  import bti_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [127:0]         out_tdata,
  input logic [1:0]           out_tuser,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // a stalled result word holds
  `BTI_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // stack errors carry no segment
  `BTI_ASSERT(a_err_zero, out_tvalid && (out_tuser != KIND_SEGMENT) |-> out_tdata == 128'd0, "error word with nonzero data")

  // after reset the table loads before symbols are taken
  `BTI_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !in_tready && !out_tvalid, "not quiet after reset")

  // a new start heading reloads the table, in_tready low through both load states
  `BTI_ASSERT(a_hd_reload, cfg_valid && cfg_ready && (cfg_index == CFG_START_HEADING) |=> !in_tready ##1 !in_tready, "input taken during table reload")

endmodule

bind bracketed_turtle_interpreter bti_checker u_bti_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_index  (cfg_index)
);
